// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files of the word frequency table.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check cond at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Check that trig implies cond in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");
`endif

// ===== design/wft_pkg.sv =====
// Package of the word frequency table: defaults, codes, types.
// No dependencies.
package wft_pkg;
   localparam int DEFAULT_TABLE_DEPTH  = 256;
   localparam int DEFAULT_MAX_WORD_LEN = 32;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CFG_WIDTH            = 6;
   localparam int CSR_IDX_WIDTH        = 4;
   localparam int HASH_WIDTH           = 64;
   localparam int COUNT_WIDTH          = 32;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_QUERY = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_QUERY = CSR_IDX_WIDTH'(1);
   localparam logic [CFG_WIDTH-1:0] MIN_QUERY_RESET = CFG_WIDTH'(3);
   localparam logic [CFG_WIDTH-1:0] MAX_QUERY_RESET = CFG_WIDTH'(30);

   typedef enum logic [2:0] {
      STAT_COUNTED  = 3'd0,
      STAT_ADDED    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_TOO_LONG = 3'd4,
      STAT_FOUND    = 3'd5,
      STAT_MISS     = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_TRIM_END, BK_TRIM_START, BK_HASH, BK_SEARCH_RD, BK_SEARCH_CMP,
      BK_CHAR_RD, BK_CHAR_CMP, BK_COUNT_UPD, BK_INSERT, BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] min_len;
      logic [CFG_WIDTH-1:0] max_len;
   } cfg_type;
endpackage

// ===== design/wft_req_if.sv =====
// Input channel of the word frequency table: one byte per transfer.
// Depends on nothing.
interface wft_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_code;
   logic       word_end;
   modport source (output valid, func, char_code, word_end, input ready);
   modport sink (input valid, func, char_code, word_end, output ready);
endinterface

// ===== design/wft_rsp_if.sv =====
// Result channel of the word frequency table.
// Depends on nothing.
interface wft_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  entry_index;
   logic [31:0] occurrences;
   logic [31:0] added_total;
   modport source (output valid, status, entry_index, occurrences, added_total, input ready);
   modport sink (input valid, status, entry_index, occurrences, added_total, output ready);
endinterface

// ===== design/wft_csr_if.sv =====
// Configuration write channel of the word frequency table.
// Depends on nothing.
interface wft_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [5:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/wft_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/wft_fifo.sv =====
// Short job queue between the front and back parts.
// Uses wft_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wft_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   import wft_pkg::*;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CNW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNW-1:0]   count_ff, count_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign full = (count_ff == CNW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ff];

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, count_ff < CNW'(QUEUE_DEPTH))
endmodule

// ===== design/wft_front.sv =====
// Front part: collects bytes of a word and queues the closed word as a job.
// Uses wft_pkg and wft_req_if.
module wft_front #(
   parameter int MAX_WORD_LEN = 32,
   parameter int JOB_WIDTH = 8 * MAX_WORD_LEN + $clog2(MAX_WORD_LEN + 1) + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   wft_req_if.sink              req,
   input  logic                 q_full,
   output logic                 push,
   output logic [JOB_WIDTH-1:0] push_data
);
   import wft_pkg::*;
   localparam int LW = $clog2(MAX_WORD_LEN + 1);

   logic [MAX_WORD_LEN-1:0][7:0] buf_ff, buf_in;
   logic [LW-1:0]                len_ff, len_in, len_next;
   logic                         ovf_ff, ovf_in, ovf_next;
   logic                         take;

   assign req.ready = !q_full;
   assign take = req.valid && req.ready;

   always_comb begin
      buf_in = buf_ff;
      len_next = len_ff;
      ovf_next = ovf_ff;
      if (len_ff < LW'(MAX_WORD_LEN)) begin
         buf_in[len_ff[$clog2(MAX_WORD_LEN)-1:0]] = req.char_code;
         len_next = len_ff + LW'(1);
      end else begin
         ovf_next = 1'b1;
      end
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (take) begin
         // restart the word after the closing byte
         len_in = req.word_end ? '0 : len_next;
         ovf_in = req.word_end ? 1'b0 : ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
      if (take) begin
         buf_ff <= buf_in;
      end
   end

   assign push = take && req.word_end;
   assign push_data = {req.func, ovf_next, len_next, buf_in};
endmodule

// ===== design/wft_back.sv =====
// Back part: trims query words, hashes, searches the table and updates it for counted words, one job at a time.
// Uses wft_pkg, wft_ram, wft_rsp_if and assert_macros.svh.
`include "assert_macros.svh"
module wft_back #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_WORD_LEN = 32,
   parameter int JOB_WIDTH = 8 * MAX_WORD_LEN + $clog2(MAX_WORD_LEN + 1) + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wft_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   input  logic [JOB_WIDTH-1:0] q_data,
   output logic                 q_pop,
   wft_rsp_if.source            rsp
);
   import wft_pkg::*;
   localparam int LW = $clog2(MAX_WORD_LEN + 1);
   localparam int SW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CD = TABLE_DEPTH * MAX_WORD_LEN;
   localparam int CW = $clog2(CD);
   localparam int MW = HASH_WIDTH + LW;
   localparam int BW = 8 * MAX_WORD_LEN;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
   endfunction

   function automatic logic is_pad(input logic [7:0] c);
      return c == 8'h20 || c == 8'h5f;
   endfunction

   back_state_type        state_ff, state_in;
   logic [LW-1:0]         n_ff, n_in, start_ff, start_in, i_ff, i_in, rd_idx;
   logic [HASH_WIDTH-1:0] h_ff, h_in;
   logic [SW-1:0]         slot_ff, slot_in, used_ff, used_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in, occ_ff, occ_in;
   status_type            stat_ff, stat_in;
   logic [7:0]            index_ff, index_in;
   logic                  rv_ff, rv_in;
   logic [2:0]            rs_ff, rs_in;
   logic [7:0]            ri_ff, ri_in;
   logic [31:0]           ro_ff, ro_in, rt_ff, rt_in;

   logic [BW-1:0]  q_bytes;
   logic [LW-1:0]  q_raw;
   logic           q_ovf, q_func;
   logic [7:0]     cur_byte;
   logic [LW-1:0]  trimmed;

   logic                   meta_we, cnt_we, chr_we;
   logic [MW-1:0]          meta_wdata, meta_rdata;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
   logic [7:0]             chr_rdata;
   logic [CW-1:0]          chr_addr;
   logic [AW-1:0]          slot_addr;

   assign q_bytes = q_data[BW-1:0];
   assign q_raw = q_data[BW +: LW];
   assign q_ovf = q_data[BW + LW];
   assign q_func = q_data[BW + LW + 1];
   assign slot_addr = slot_ff[AW-1:0];
   assign chr_addr = CW'(slot_addr) * CW'(MAX_WORD_LEN) + CW'(i_ff);
   assign trimmed = n_ff - start_ff;

   always_comb begin
      case (state_ff)
         BK_IDLE:       rd_idx = q_raw - LW'(1);
         BK_TRIM_END:   rd_idx = n_ff - LW'(1);
         BK_TRIM_START: rd_idx = start_ff;
         default:       rd_idx = start_ff + i_ff;
      endcase
   end

   assign cur_byte = upcase(q_bytes[rd_idx * 8 +: 8]);

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      start_in = start_ff;
      i_in = i_ff;
      h_in = h_ff;
      slot_in = slot_ff;
      used_in = used_ff;
      total_in = total_ff;
      occ_in = occ_ff;
      stat_in = stat_ff;
      index_in = index_ff;
      rv_in = rv_ff && !rsp.ready;
      rs_in = rs_ff;
      ri_in = ri_ff;
      ro_in = ro_ff;
      rt_in = rt_ff;
      q_pop = 1'b0;
      meta_we = 1'b0;
      cnt_we = 1'b0;
      chr_we = 1'b0;
      meta_wdata = {h_ff, n_ff};
      cnt_wdata = cnt_rdata + COUNT_WIDTH'(1);
      case (state_ff)
         BK_IDLE: begin
            start_in = '0;
            i_in = '0;
            h_in = '0;
            slot_in = '0;
            occ_in = '0;
            index_in = '0;
            stat_in = STAT_MISS;
            n_in = q_raw;
            if (q_valid) begin
               if (q_ovf) begin
                  stat_in = STAT_TOO_LONG;
                  state_in = BK_RESULT;
               end else if (!q_func) begin
                  // drop a single trailing NUL
                  if (q_raw != '0 && cur_byte == 8'h00) begin
                     n_in = q_raw - LW'(1);
                  end
                  if (q_raw == '0 || (q_raw == LW'(1) && cur_byte == 8'h00)) begin
                     stat_in = STAT_EMPTY;
                     state_in = BK_RESULT;
                  end else begin
                     state_in = BK_HASH;
                  end
               end else if (32'(q_raw) >= 32'(cfg.min_len) &&
                            32'(q_raw) <= 32'(cfg.max_len)) begin
                  state_in = BK_TRIM_END;
               end else begin
                  state_in = BK_RESULT;
               end
            end
         end
         BK_TRIM_END: begin
            if (n_ff != '0 && is_pad(cur_byte)) begin
               n_in = n_ff - LW'(1);
            end else begin
               state_in = BK_TRIM_START;
            end
         end
         BK_TRIM_START: begin
            if (start_ff < n_ff && is_pad(cur_byte)) begin
               start_in = start_ff + LW'(1);
            end else begin
               n_in = trimmed;
               state_in = (trimmed == '0) ? BK_RESULT : BK_HASH;
            end
         end
         BK_HASH: begin
            // sdbm stops at the first zero byte
            if (i_ff < n_ff && cur_byte != 8'h00) begin
               h_in = HASH_WIDTH'(cur_byte) + (h_ff << 6) + (h_ff << 16) - h_ff;
               i_in = i_ff + LW'(1);
            end else begin
               state_in = BK_SEARCH_RD;
            end
         end
         BK_SEARCH_RD: begin
            i_in = '0;
            if (slot_ff < used_ff) begin
               state_in = BK_SEARCH_CMP;
            end else if (q_func) begin
               state_in = BK_RESULT;
            end else if (used_ff >= SW'(TABLE_DEPTH)) begin
               stat_in = STAT_FULL;
               state_in = BK_RESULT;
            end else begin
               slot_in = used_ff;
               state_in = BK_INSERT;
            end
         end
         BK_SEARCH_CMP: begin
            if (meta_rdata == {h_ff, n_ff}) begin
               state_in = BK_CHAR_RD;
            end else begin
               slot_in = slot_ff + SW'(1);
               state_in = BK_SEARCH_RD;
            end
         end
         BK_CHAR_RD: begin
            state_in = (i_ff == n_ff) ? BK_COUNT_UPD : BK_CHAR_CMP;
         end
         BK_CHAR_CMP: begin
            if (chr_rdata == cur_byte) begin
               i_in = i_ff + LW'(1);
               state_in = BK_CHAR_RD;
            end else begin
               slot_in = slot_ff + SW'(1);
               state_in = BK_SEARCH_RD;
            end
         end
         BK_COUNT_UPD: begin
            index_in = 8'(slot_ff);
            if (q_func) begin
               stat_in = STAT_FOUND;
               occ_in = cnt_rdata;
            end else begin
               cnt_we = 1'b1;
               stat_in = STAT_COUNTED;
               occ_in = cnt_wdata;
               total_in = total_ff + COUNT_WIDTH'(1);
            end
            state_in = BK_RESULT;
         end
         BK_INSERT: begin
            if (i_ff < n_ff) begin
               chr_we = 1'b1;
               i_in = i_ff + LW'(1);
            end else begin
               meta_we = 1'b1;
               cnt_we = 1'b1;
               cnt_wdata = COUNT_WIDTH'(1);
               used_in = used_ff + SW'(1);
               total_in = total_ff + COUNT_WIDTH'(1);
               stat_in = STAT_ADDED;
               occ_in = COUNT_WIDTH'(1);
               index_in = 8'(slot_ff);
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            // hold until the output register is free
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rs_in = stat_ff;
               ri_in = index_ff;
               ro_in = occ_ff;
               rt_in = total_ff;
               q_pop = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         used_ff <= '0;
         total_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         total_ff <= total_in;
         rv_ff <= rv_in;
      end
      n_ff <= n_in;
      start_ff <= start_in;
      i_ff <= i_in;
      h_ff <= h_in;
      slot_ff <= slot_in;
      occ_ff <= occ_in;
      stat_ff <= stat_in;
      index_ff <= index_in;
      rs_ff <= rs_in;
      ri_ff <= ri_in;
      ro_ff <= ro_in;
      rt_ff <= rt_in;
   end

   wft_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_meta (
      .clock(clock), .we(meta_we), .waddr(slot_addr), .wdata(meta_wdata),
      .raddr(slot_addr), .rdata(meta_rdata)
   );

   wft_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_DEPTH)) u_count (
      .clock(clock), .we(cnt_we), .waddr(slot_addr), .wdata(cnt_wdata),
      .raddr(slot_addr), .rdata(cnt_rdata)
   );

   wft_ram #(.WIDTH(8), .DEPTH(CD)) u_chars (
      .clock(clock), .we(chr_we), .waddr(chr_addr), .wdata(cur_byte),
      .raddr(chr_addr), .rdata(chr_rdata)
   );

   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.entry_index = ri_ff;
   assign rsp.occurrences = ro_ff;
   assign rsp.added_total = rt_ff;

   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= SW'(TABLE_DEPTH))
   `ASSERT_IMPLIES(a_pop_has_job, clock, reset, q_pop, q_valid)
endmodule

// ===== design/word_frequency_table.sv =====
// A word that is too long or empty, or a query whose length is out of range, skips the table search.
// Throughput: one byte per cycle while the two-entry job queue has room; one word at a time.
// Reset: synchronous; clears control registers, counters, fill count and queue; RAMs are kept.
module word_frequency_table #(
   parameter int TABLE_DEPTH = wft_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_WORD_LEN = wft_pkg::DEFAULT_MAX_WORD_LEN
) (
   input logic       clock,
   input logic       reset,
   wft_req_if.sink   req_chan,
   wft_rsp_if.source rsp_chan,
   wft_csr_if.sink   csr_chan
);
   import wft_pkg::*;
   localparam int JW = 8 * MAX_WORD_LEN + $clog2(MAX_WORD_LEN + 1) + 2;

   cfg_type        cfg_ff, cfg_in;
   logic           push, pop, full, not_empty;
   logic [JW-1:0]  push_data, head_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MIN_QUERY: cfg_in.min_len = csr_chan.data;
            CSR_MAX_QUERY: cfg_in.max_len = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{min_len: MIN_QUERY_RESET, max_len: MAX_QUERY_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wft_front #(.MAX_WORD_LEN(MAX_WORD_LEN), .JOB_WIDTH(JW)) u_front (
      .clock(clock), .reset(reset), .req(req_chan), .q_full(full),
      .push(push), .push_data(push_data)
   );

   wft_fifo #(.WIDTH(JW)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .pop(pop),
      .full(full), .not_empty(not_empty), .head_data(head_data)
   );

   wft_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN), .JOB_WIDTH(JW)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(not_empty), .q_data(head_data),
      .q_pop(pop), .rsp(rsp_chan)
   );
endmodule
